/* hdl/binary_gps_frame_deframer_defines.svh */
// Assertion macros shared by the deframer RTL.
// Included by the modules that carry concurrent assertions.
`ifndef BINARY_GPS_FRAME_DEFRAMER_DEFINES_SVH
`define BINARY_GPS_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BGFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset.
`define BGFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

/* hdl/bgfd_pkg.sv */
// Shared types and constants of the binary GPS frame deframer.
// No dependencies; used by all deframer modules.
`default_nettype none

package bgfd_pkg;

  localparam logic [7:0]  SYNC_HI       = 8'hA0;
  localparam logic [7:0]  SYNC_LO       = 8'hA2;
  localparam logic [7:0]  FOOT_HI       = 8'hB0;
  localparam logic [7:0]  FOOT_LO       = 8'hB3;
  localparam logic [15:0] SUM_MASK      = 16'h7FFF;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1023;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_CKSUM_ERR = 2'd1,
    STATUS_FOOT_ERR = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    status_t     frame_status;
    logic [7:0]  message_id_out;
    logic [15:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

/* hdl/bgfd_channels.sv */
// Valid/ready channel interfaces of the deframer: byte input, result output
// and configuration write. No dependencies.
`default_nettype none

interface bgfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface bgfd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [1:0]  frame_status;
  logic [7:0]  message_id_out;
  logic [15:0] frame_length;
  modport source (output valid, output result_kind, output payload_byte,
                  output byte_index, output frame_status, output message_id_out,
                  output frame_length, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input byte_index, input frame_status, input message_id_out,
                input frame_length, output ready);
endinterface

interface bgfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_payload_len;
  modport source (output valid, output max_payload_len, input ready);
  modport sink (input valid, input max_payload_len, output ready);
endinterface

`default_nettype wire

/* hdl/bgfd_parser.sv */
// Frame state machine: sync hunt, length, payload, checksum and footer.
// Depends on bgfd_pkg and the assertion macros header.
`default_nettype none
`include "binary_gps_frame_deframer_defines.svh"

module bgfd_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [15:0]       max_len,
  output logic                   res_valid,
  output bgfd_pkg::result_t      res
);

  typedef enum logic [3:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CK_HI,
    PH_CK_LO,
    PH_FT_HI,
    PH_FT_LO
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] received_checksum, received_checksum_next;
  logic        footer_first_ok, footer_first_ok_next;
  logic [7:0]  first_payload_byte, first_payload_byte_next;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic        len_reject;

  assign len_full   = {payload_length[15:8], rx_byte};
  assign count_inc  = byte_count + 16'd1;
  assign len_reject = (phase == PH_LEN_LO) && (len_full == 16'd0 || len_full > max_len);

  always_comb begin
    phase_next              = phase;
    payload_length_next     = payload_length;
    byte_count_next         = byte_count;
    running_sum_next        = running_sum;
    received_checksum_next  = received_checksum;
    footer_first_ok_next    = footer_first_ok;
    first_payload_byte_next = first_payload_byte;
    res_valid               = 1'b0;
    res                     = '0;
    res.result_kind         = bgfd_pkg::KIND_PAYLOAD;
    res.frame_status        = bgfd_pkg::STATUS_GOOD;

    case (phase)
      PH_HUNT0: begin
        phase_next = (rx_byte == bgfd_pkg::SYNC_HI) ? PH_HUNT1 : PH_HUNT0;
      end
      PH_HUNT1: begin
        // a repeated first sync byte keeps the hunt armed
        if (rx_byte == bgfd_pkg::SYNC_LO) begin
          phase_next = PH_LEN_HI;
        end else if (rx_byte == bgfd_pkg::SYNC_HI) begin
          phase_next = PH_HUNT1;
        end else begin
          phase_next = PH_HUNT0;
        end
      end
      PH_LEN_HI: begin
        payload_length_next = {rx_byte, 8'h00};
        phase_next          = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_length_next = len_full;
        if (len_reject) begin
          phase_next = PH_HUNT0;
        end else begin
          byte_count_next         = '0;
          running_sum_next        = '0;
          first_payload_byte_next = '0;
          phase_next              = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.payload_byte = rx_byte;
        res.byte_index   = byte_count;
        if (byte_count == 16'd0) begin
          first_payload_byte_next = rx_byte;
        end
        running_sum_next = running_sum + {8'h00, rx_byte};
        byte_count_next  = count_inc;
        if (count_inc >= payload_length) begin
          phase_next = PH_CK_HI;
        end
      end
      PH_CK_HI: begin
        received_checksum_next = {rx_byte, 8'h00};
        phase_next             = PH_CK_LO;
      end
      PH_CK_LO: begin
        received_checksum_next = {received_checksum[15:8], rx_byte};
        phase_next             = PH_FT_HI;
      end
      PH_FT_HI: begin
        footer_first_ok_next = (rx_byte == bgfd_pkg::FOOT_HI);
        phase_next           = PH_FT_LO;
      end
      PH_FT_LO: begin
        res_valid          = 1'b1;
        res.result_kind    = bgfd_pkg::KIND_VERDICT;
        res.message_id_out = first_payload_byte;
        res.frame_length   = payload_length;
        // footer check wins over checksum check
        if (!footer_first_ok || rx_byte != bgfd_pkg::FOOT_LO) begin
          res.frame_status = bgfd_pkg::STATUS_FOOT_ERR;
        end else if (received_checksum != (running_sum & bgfd_pkg::SUM_MASK)) begin
          res.frame_status = bgfd_pkg::STATUS_CKSUM_ERR;
        end else begin
          res.frame_status = bgfd_pkg::STATUS_GOOD;
        end
        phase_next = PH_HUNT0;
      end
      default: begin
        phase_next = PH_HUNT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT0;
      payload_length     <= '0;
      byte_count         <= '0;
      running_sum        <= '0;
      received_checksum  <= '0;
      footer_first_ok    <= 1'b0;
      first_payload_byte <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      payload_length     <= payload_length_next;
      byte_count         <= byte_count_next;
      running_sum        <= running_sum_next;
      received_checksum  <= received_checksum_next;
      footer_first_ok    <= footer_first_ok_next;
      first_payload_byte <= first_payload_byte_next;
    end
  end

  `BGFD_ASSERT_IMP(a_payload_len_nonzero, clk, rst, phase == PH_PAYLOAD, payload_length != 16'd0)
  `BGFD_ASSERT_IMP(a_count_in_range, clk, rst, phase == PH_PAYLOAD, byte_count < payload_length)
  `BGFD_ASSERT_NXT(a_verdict_rehunts, clk, rst, accept && phase == PH_FT_LO, phase == PH_HUNT0)
  `BGFD_ASSERT_NXT(a_bad_len_rehunts, clk, rst, accept && len_reject, phase == PH_HUNT0)

endmodule

`default_nettype wire

/* hdl/bgfd_out_reg.sv */
// Result register between the frame state machine and the output channel.
// Depends on bgfd_pkg and bgfd_channels.
`default_nettype none

module bgfd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic              res_valid,
  input  wire bgfd_pkg::result_t res_in,
  output logic                   space,
  bgfd_result_if.source          frames
);

  logic              valid;
  bgfd_pkg::result_t data;

  // room for a new word when empty or when the held word leaves this cycle
  assign space = !valid || frames.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= res_valid;
    end else if (frames.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data <= res_in;
    end
  end

  assign frames.valid          = valid;
  assign frames.result_kind    = data.result_kind;
  assign frames.payload_byte   = data.payload_byte;
  assign frames.byte_index     = data.byte_index;
  assign frames.frame_status   = data.frame_status;
  assign frames.message_id_out = data.message_id_out;
  assign frames.frame_length   = data.frame_length;

endmodule

`default_nettype wire

/* hdl/binary_gps_frame_deframer.sv */
// Result words are registered: each appears in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single output register stalls input
// only while it holds a word that the sink does not take.
// Reset (rst, synchronous): sync hunt restarts with no sync byte seen, frame
// state clears, output empties, max_payload_len returns to 1023.
`default_nettype none

module binary_gps_frame_deframer (
  input  wire logic     clk,
  input  wire logic     rst,
  bgfd_byte_if.sink     rx,
  bgfd_cfg_if.sink      cfg,
  bgfd_result_if.source frames
);

  logic [15:0]       max_payload_len;
  logic              space;
  logic              accept;
  logic              res_valid;
  bgfd_pkg::result_t res;

  assign cfg.ready = 1'b1;
  assign rx.ready  = space;
  assign accept    = rx.valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= bgfd_pkg::MAX_LEN_RESET;
    end else if (cfg.valid) begin
      max_payload_len <= cfg.max_payload_len;
    end
  end

  bgfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .max_len   (max_payload_len),
    .res_valid (res_valid),
    .res       (res)
  );

  bgfd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_valid (res_valid),
    .res_in    (res),
    .space     (space),
    .frames    (frames)
  );

endmodule

`default_nettype wire
